// ===== rtl/core/p3ke_pkg.sv =====
// p3ke_pkg: shared types, widths and constants for the degree-3 polynomial embedding.
// No dependencies.
package p3ke_pkg;

  localparam int MAX_DIM     = 16;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int CNT_W       = $clog2(MAX_DIM + 1);
  localparam int DIM_W       = 5;
  localparam int ELEM_W      = 16;
  localparam int COORD_W     = 32;
  localparam int POS_W       = 10;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int WGT_W       = 18;
  localparam int PROD_W      = 48;

  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCUMULATE = 1'd1;

  // Q.16 weights: 1, sqrt3, sqrt6
  localparam logic [WGT_W-1:0] W_ONE   = 18'd65536;
  localparam logic [WGT_W-1:0] W_SQRT3 = 18'd113512;
  localparam logic [WGT_W-1:0] W_SQRT6 = 18'd160530;

  typedef enum logic [1:0] {
    GRP_CUBE   = 2'd0,
    GRP_PAIR   = 2'd1,
    GRP_TRIPLE = 2'd2
  } p3ke_group_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_SATURATED  = 2'd2
  } p3ke_status_t;

  typedef struct packed {
    p3ke_group_t               grp;
    logic                      err;
    logic                      acc;
    logic                      last;
    logic [POS_W-1:0]          pos;
    logic signed [COORD_W-1:0] prior;
  } p3ke_meta_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic signed [ELEM_W-1:0] c;
    p3ke_meta_t               meta;
  } p3ke_job_t;

endpackage

// ===== rtl/core/p3ke_if.sv =====
// p3ke_if: valid/ready channel interfaces for input beats and result beats.
// Depends on p3ke_pkg.
interface p3ke_in_if import p3ke_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [ELEM_W-1:0]  element_value;
  logic signed [COORD_W-1:0] prior_value;

  modport source (output valid, output operation, output element_value,
                  output prior_value, input ready);
  modport sink   (input valid, input operation, input element_value,
                  input prior_value, output ready);
endinterface

interface p3ke_out_if import p3ke_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coordinate;
  logic [POS_W-1:0]          coordinate_index;
  logic                      final_flag;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output coordinate, output coordinate_index,
                  output final_flag, output status, input ready);
  modport sink   (input valid, input coordinate, input coordinate_index,
                  input final_flag, input status, output ready);
endinterface

// ===== rtl/core/poly3_kernel_embedding.sv =====
// poly3_kernel_embedding: top level of the degree-3 explicit polynomial embedding.
// Depends on p3ke_pkg, p3ke_if, p3ke_front, p3ke_fifo, p3ke_back.
//
// Usage:
//   in_chan beats carry an operation: load appends element_value to the
//   vector, emit asks for the next embedding coordinate (prior_value is added
//   when accumulate_mode is set). Loads produce no beat on out_chan; every
//   emit produces exactly one, in order.
//   cfg_we/cfg_index/cfg_data write dimension (index 0) or accumulate_mode
//   (index 1); write them only while no emit is outstanding. A dimension
//   write restarts loading.
//   Throughput: one beat per cycle while out_chan is ready and the queue
//   has room, as three register-read RAM copies fetch all operands at once
//   and the multiply chain is fully pipelined.
//   Reset clears the sequencer, the queue and out_chan.valid; dimension
//   returns to 16, accumulate_mode to 0. Vector contents are unknown until
//   loaded.
//   When out_chan stalls the back pipeline holds, the 4-entry queue fills,
//   and in_chan.ready drops until room frees.
module poly3_kernel_embedding import p3ke_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  p3ke_in_if.sink               in_chan,
  p3ke_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic               push, pop, empty;
  p3ke_job_t          push_job, head_job;
  logic [FIFO_CW-1:0] fifo_count;

  p3ke_front u_front (
    .clk, .rst_n, .in_chan, .cfg_we, .cfg_index, .cfg_data,
    .fifo_count, .push, .push_job
  );

  p3ke_fifo u_fifo (
    .clk, .rst_n, .push, .push_job, .pop, .head_job, .empty, .count(fifo_count)
  );

  p3ke_back u_back (
    .clk, .rst_n, .head_job, .empty, .pop, .out_chan
  );

endmodule

// ===== rtl/core/p3ke_ram.sv =====
// p3ke_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module p3ke_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/core/p3ke_front.sv =====
// p3ke_front: config registers, vector loading, coordinate sequencing and operand fetch.
// Depends on p3ke_pkg, p3ke_if, p3ke_ram.
module p3ke_front import p3ke_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  p3ke_in_if.sink               in_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FIFO_CW-1:0]    fifo_count,
  output logic                  push,
  output p3ke_job_t             push_job
);

  localparam int CW = CNT_W + 1;

  logic [DIM_W-1:0] dim_r;
  logic             acc_r;
  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] fi_r, fi_nxt, si_r, si_nxt, ti_r, ti_nxt;
  p3ke_group_t      grp_r, grp_nxt;
  logic             pend_v_r;
  p3ke_meta_t       pend_meta_r, pend_meta_nxt;

  logic [CW-1:0]    dim_eff;
  logic             full;
  logic             fire, load_fire, emit_fire, load_we, done;
  logic [ELEM_W-1:0] rd_a, rd_b, rd_c;

  always_comb begin
    if (dim_r == '0) begin
      dim_eff = CW'(1);
    end else if (int'(dim_r) > MAX_DIM) begin
      dim_eff = CW'(MAX_DIM);
    end else begin
      dim_eff = CW'(dim_r);
    end
  end

  assign full          = CW'(loaded_r) >= dim_eff;
  assign in_chan.ready = (int'(fifo_count) + int'(pend_v_r)) < FIFO_DEPTH;
  assign fire          = in_chan.valid && in_chan.ready;
  assign load_fire     = fire && !in_chan.operation;
  assign emit_fire     = fire && in_chan.operation;
  assign load_we       = load_fire && !full;

  // index sequencer
  always_comb begin
    logic [CW-1:0] f, s, t;
    f        = CW'(fi_r);
    s        = CW'(si_r);
    t        = CW'(ti_r);
    done     = 1'b0;
    grp_nxt  = grp_r;
    case (grp_r)
      GRP_CUBE: begin
        f = f + 1'b1;
        if (f >= dim_eff) begin
          if (dim_eff < CW'(2)) begin
            done = 1'b1;
          end else begin
            grp_nxt = GRP_PAIR;
            f = '0;
            s = CW'(1);
          end
        end
      end
      GRP_PAIR: begin
        s = s + 1'b1;
        if (s == f) begin
          s = s + 1'b1;
        end
        if (s >= dim_eff) begin
          f = f + 1'b1;
          s = '0;
          if (f >= dim_eff) begin
            if (dim_eff < CW'(3)) begin
              done = 1'b1;
            end else begin
              grp_nxt = GRP_TRIPLE;
              f = '0;
              s = CW'(1);
              t = CW'(2);
            end
          end
        end
      end
      GRP_TRIPLE: begin
        t = t + 1'b1;
        if (t >= dim_eff) begin
          s = s + 1'b1;
          t = s + 1'b1;
          if (t >= dim_eff) begin
            f = f + 1'b1;
            s = f + 1'b1;
            t = f + CW'(2);
            done = t >= dim_eff;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
    fi_nxt = f[IDX_W-1:0];
    si_nxt = s[IDX_W-1:0];
    ti_nxt = t[IDX_W-1:0];
  end

  always_comb begin
    pend_meta_nxt.grp   = grp_r;
    pend_meta_nxt.err   = !full;
    pend_meta_nxt.acc   = acc_r;
    pend_meta_nxt.last  = full && done;
    pend_meta_nxt.pos   = pos_r;
    pend_meta_nxt.prior = in_chan.prior_value;
    loaded_nxt          = loaded_r + CNT_W'(load_we);
    pos_nxt             = pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r    <= DIM_W'(16);
      acc_r    <= 1'b0;
      loaded_r <= '0;
      pos_r    <= '0;
      fi_r     <= '0;
      si_r     <= '0;
      ti_r     <= '0;
      grp_r    <= GRP_CUBE;
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= emit_fire;
      if (cfg_we && cfg_index == REG_ACCUMULATE) begin
        acc_r <= cfg_data[0];
      end
      if (cfg_we && cfg_index == REG_DIMENSION) begin
        dim_r    <= cfg_data[DIM_W-1:0];
        loaded_r <= '0;
        pos_r    <= '0;
        fi_r     <= '0;
        si_r     <= '0;
        ti_r     <= '0;
        grp_r    <= GRP_CUBE;
      end else if (load_fire) begin
        loaded_r <= loaded_nxt;
      end else if (emit_fire && full) begin
        if (done) begin
          loaded_r <= '0;
          pos_r    <= '0;
          fi_r     <= '0;
          si_r     <= '0;
          ti_r     <= '0;
          grp_r    <= GRP_CUBE;
        end else begin
          pos_r <= pos_nxt;
          fi_r  <= fi_nxt;
          si_r  <= si_nxt;
          ti_r  <= ti_nxt;
          grp_r <= grp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      pend_meta_r <= pend_meta_nxt;
    end
  end

  // one copy per operand so all three read in the same cycle
  p3ke_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_ram_a (
    .clk, .we(load_we), .waddr(loaded_r[IDX_W-1:0]), .wdata(in_chan.element_value),
    .re(emit_fire), .raddr(fi_r), .rdata(rd_a)
  );
  p3ke_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_ram_b (
    .clk, .we(load_we), .waddr(loaded_r[IDX_W-1:0]), .wdata(in_chan.element_value),
    .re(emit_fire), .raddr(si_r), .rdata(rd_b)
  );
  p3ke_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_ram_c (
    .clk, .we(load_we), .waddr(loaded_r[IDX_W-1:0]), .wdata(in_chan.element_value),
    .re(emit_fire), .raddr(ti_r), .rdata(rd_c)
  );

  assign push          = pend_v_r;
  assign push_job.a    = rd_a;
  assign push_job.b    = rd_b;
  assign push_job.c    = rd_c;
  assign push_job.meta = pend_meta_r;

endmodule

// ===== rtl/core/p3ke_fifo.sv =====
// p3ke_fifo: short job queue between the sequencing front and the arithmetic back.
// Depends on p3ke_pkg.
module p3ke_fifo import p3ke_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  p3ke_job_t          push_job,
  input  logic               pop,
  output p3ke_job_t          head_job,
  output logic               empty,
  output logic [FIFO_CW-1:0] count
);

  p3ke_job_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job = mem_r[rd_ptr_r];
  assign empty    = count_r == '0;
  assign count    = count_r;

endmodule

// ===== rtl/core/p3ke_back.sv =====
// p3ke_back: multiply, weight, round, accumulate and saturate pipeline with output register.
// Depends on p3ke_pkg, p3ke_if.
module p3ke_back import p3ke_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  p3ke_job_t  head_job,
  input  logic       empty,
  output logic       pop,
  p3ke_out_if.source out_chan
);

  localparam int AB_W  = 2 * ELEM_W;
  localparam int LO_W  = 23;
  localparam int HI_W  = PROD_W - LO_W;
  localparam int HW_W  = HI_W + WGT_W + 1;
  localparam int LW_W  = LO_W + WGT_W;
  localparam int SUM_W = 64;
  localparam int SH    = 35;

  logic en;
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  p3ke_meta_t m1_r, m2_r, m3_r, m4_r;

  logic signed [ELEM_W-1:0]  ja, jb, jc, y, z;
  logic signed [AB_W-1:0]    ab_r;
  logic signed [ELEM_W-1:0]  z1_r;
  logic signed [PROD_W-1:0]  p2_r;
  logic signed [HW_W-1:0]    hiw_r;
  logic [LW_W-1:0]           low_r;
  logic signed [COORD_W-1:0] c4_r;
  logic [WGT_W-1:0]          wgt;
  logic signed [HI_W-1:0]    p_hi;
  logic [LO_W-1:0]           p_lo;
  logic signed [SUM_W-1:0]   sum4;
  logic signed [COORD_W:0]   acc_sum;

  logic signed [COORD_W-1:0] coord_r, coord_nxt;
  logic [POS_W-1:0]          index_r;
  logic                      last_r;
  p3ke_status_t              status_r, status_nxt;

  assign en  = !(ov_r && !out_chan.ready);
  assign pop = en && !empty;

  assign ja = head_job.a;
  assign jb = head_job.b;
  assign jc = head_job.c;

  always_comb begin
    y = (head_job.meta.grp == GRP_TRIPLE) ? jb : ja;
    case (head_job.meta.grp)
      GRP_CUBE: z = ja;
      GRP_PAIR: z = jb;
      default:  z = jc;
    endcase
    case (m2_r.grp)
      GRP_CUBE: wgt = W_ONE;
      GRP_PAIR: wgt = W_SQRT3;
      default:  wgt = W_SQRT6;
    endcase
    p_hi = p2_r[PROD_W-1:LO_W];
    p_lo = p2_r[LO_W-1:0];
    sum4 = ({{(SUM_W-HW_W){hiw_r[HW_W-1]}}, hiw_r} <<< LO_W)
         + SUM_W'(low_r)
         + (SUM_W'(1) <<< (SH - 1));
    acc_sum = {c4_r[COORD_W-1], c4_r} + {m4_r.prior[COORD_W-1], m4_r.prior};
    coord_nxt  = c4_r;
    status_nxt = ST_OK;
    if (m4_r.err) begin
      coord_nxt  = '0;
      status_nxt = ST_NOT_LOADED;
    end else if (m4_r.acc) begin
      coord_nxt = acc_sum[COORD_W-1:0];
      if (acc_sum[COORD_W] != acc_sum[COORD_W-1]) begin
        coord_nxt  = acc_sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                      : {1'b0, {(COORD_W-1){1'b1}}};
        status_nxt = ST_SATURATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= !empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      ov_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ab_r     <= AB_W'(ja) * AB_W'(y);
      z1_r     <= z;
      m1_r     <= head_job.meta;
      p2_r     <= PROD_W'(ab_r) * PROD_W'(z1_r);
      m2_r     <= m1_r;
      hiw_r    <= HW_W'(p_hi) * HW_W'($signed({1'b0, wgt}));
      low_r    <= LW_W'(p_lo) * LW_W'(wgt);
      m3_r     <= m2_r;
      c4_r     <= COORD_W'(sum4 >>> SH);
      m4_r     <= m3_r;
      coord_r  <= coord_nxt;
      index_r  <= m4_r.pos;
      last_r   <= m4_r.last;
      status_r <= status_nxt;
    end
  end

  assign out_chan.valid            = ov_r;
  assign out_chan.coordinate       = coord_r;
  assign out_chan.coordinate_index = index_r;
  assign out_chan.final_flag       = last_r;
  assign out_chan.status           = status_r;

endmodule

// ===== rtl/core/p3ke_checker.sv =====
// p3ke_checker: port-level assertions for poly3_kernel_embedding, bound to the top level.
// Depends on p3ke_pkg and poly3_kernel_embedding.
module p3ke_checker import p3ke_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] coordinate,
  input logic                      final_flag,
  input logic [STATUS_W-1:0]       status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(coordinate) && $stable(status))
    else $error("result beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_not_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_NOT_LOADED |-> coordinate == '0 && !final_flag)
    else $error("not-loaded beat has payload");

  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_SATURATED |->
      coordinate == 32'sh7fffffff || coordinate == 32'sh80000000)
    else $error("saturated beat not clamped");

endmodule

bind poly3_kernel_embedding p3ke_checker u_p3ke_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .coordinate (out_chan.coordinate),
  .final_flag (out_chan.final_flag),
  .status     (out_chan.status)
);
